/* rtl/lgkg_pkg.sv */
// Shared constants for the LoG / Gaussian kernel generator.
// No dependencies; imported by log_gauss_kernel_generator.
package lgkg_pkg;

    localparam int SIGMA_W      = 11;
    localparam int TAP_W        = 6;
    localparam int COEF_W       = 17;
    localparam int STORE_DEPTH  = 64;
    localparam int STORE_W      = 32;
    localparam int ACC_W        = 40;
    localparam int X_W          = 23;
    localparam int Y_W          = 24;
    localparam int U_W          = 30;
    localparam int TERM_W       = 31;
    localparam int DEN_W        = 46;
    localparam int DIFF_W       = 42;
    localparam int TAYLOR_TERMS = 10;

    localparam logic [16:0]       LOG2E_Q16 = 17'd94548;
    localparam logic [29:0]       LN2_Q30   = 30'd744261118;
    localparam logic [TERM_W-1:0] ONE_Q30   = TERM_W'(1) << 30;
    localparam logic [X_W-1:0]    X_LIMIT   = X_W'(64) << 16;
    localparam logic [COEF_W-1:0] GC_MAX    = 17'd131071;
    localparam logic [COEF_W-1:0] LC_POS_MAX = 17'd65535;
    localparam logic [COEF_W-1:0] LC_NEG_MAX = 17'd65536;

endpackage

/* rtl/log_gauss_kernel_generator.sv */
// One-axis LoG / Gaussian kernel generator, top level.
// Depends on lgkg_pkg; holds the tap stores and a shared serial divider.
//
// Each sigma beat (Q8, 1/256 sample) produces n = max(1, floor(10*sigma)) taps,
// raised to odd and capped at MAX_TAPS; one result beat per tap, tlast on the
// final one. Pass one evaluates exp() per tap (ten-term series, each term
// divided by its index through a reciprocal multiply) and writes g and LoG
// into two 64-entry stores while summing them; pass two reads each tap back,
// normalizes both coefficients and removes the LoG mean. The variable
// divisions share one restoring divider, one quotient bit per cycle, so each
// divide holds the sequencer until its quotient is ready. The block takes one
// sigma at a time: s_tready is high only when the previous kernel has been
// fully delivered.
module log_gauss_kernel_generator
    import lgkg_pkg::*;
#(
    parameter int MAX_TAPS       = 63,
    parameter int COEF_FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [10:0] sigma, [15:11] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [5:0] tap_index, [11:6] tap_count,
                                   // [28:12] log_coef, [45:29] gauss_coef
    output logic        m_tlast    // last
);

    localparam int NUM_W = 42 + COEF_FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [TAP_W-1:0] TAP_CAP =
        TAP_W'((MAX_TAPS % 2 == 1) ? MAX_TAPS : MAX_TAPS - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_SETUP, S_P1_DIV, S_X_WAIT, S_Y, S_U, S_T_MUL, S_T_DIV,
        S_T_WAIT, S_G, S_L, S_WR, S_P2, S_RD, S_GC_START, S_GC_WAIT,
        S_LC_WAIT, S_OUT
    } state_t;

    state_t state_reg;

    // item registers
    logic [SIGMA_W-1:0]   sigma_reg;
    logic [TAP_W-1:0]     n_reg;
    logic [TAP_W-1:0]     half_reg;
    logic [TAP_W-1:0]     j_reg;
    logic [21:0]          ssq_reg;
    logic [X_W-1:0]       x_reg;
    logic [Y_W-1:0]       y_reg;
    logic [7:0]           k_reg;
    logic [U_W-1:0]       u_reg;
    logic [TERM_W-1:0]    term_reg;
    logic [29:0]          tprod_reg;
    logic [TERM_W-1:0]    tq_reg;
    logic [31:0]          sum_reg;
    logic [3:0]           i_reg;
    logic [TERM_W-1:0]    g_reg;
    logic [54:0]          lprod_reg;
    logic                 rneg_reg;
    logic [ACC_W-1:0]     gacc_reg;
    logic signed [ACC_W-1:0] lacc_reg;
    logic [DEN_W-1:0]     nden_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [COEF_W-1:0]    gauss_out_reg;
    logic [COEF_W-1:0]    log_out_reg;
    logic                 m_tvalid_reg;

    // divider control
    logic                 div_start_reg;
    logic [NUM_W-1:0]     div_ld_num_reg;
    logic [DEN_W-1:0]     div_ld_den_reg;

    // divider datapath
    logic [NUM_W-1:0]     div_num_reg;
    logic [DEN_W-1:0]     div_den_reg;
    logic [DEN_W-1:0]     div_rem_reg;
    logic [NUM_W-1:0]     div_quo_reg;
    logic [CNT_W-1:0]     div_cnt_reg;
    logic                 div_busy_reg;
    logic                 div_done_reg;
    logic [DEN_W:0]       div_shift;

    // stores
    logic [STORE_W-1:0]        gauss_store [STORE_DEPTH];
    logic signed [STORE_W-1:0] log_store   [STORE_DEPTH];
    logic [STORE_W-1:0]        g_rd_reg;
    logic signed [STORE_W-1:0] l_rd_reg;

    // combinational helpers
    logic [TAP_W-1:0]     tap_dist;
    logic [9:0]           tap_dist_sq;
    logic [14:0]          ten_s;
    logic [6:0]           t_raw;
    logic [6:0]           t_odd;
    logic [TAP_W-1:0]     n_calc;
    logic signed [24:0]   r_val;
    logic [23:0]          r_mag;
    logic [39:0]          l_mag;
    logic signed [ACC_W-1:0] l_val;
    logic [DIFF_W-2:0]    diff_mag;
    logic                 wr_en;
    logic [31:0]          recip_m;
    logic [5:0]           recip_s;

    assign tap_dist    = (j_reg >= half_reg) ? (j_reg - half_reg) : (half_reg - j_reg);
    assign tap_dist_sq = 10'(tap_dist[4:0] * tap_dist[4:0]);

    assign ten_s = 15'(sigma_reg) * 15'd10;
    assign t_raw = ten_s[14:8];
    always_comb
    begin
        t_odd = (t_raw == 7'd0) ? 7'd1 : t_raw;
        if (!t_odd[0])
            t_odd = t_odd + 7'd1;
        n_calc = (t_odd > 7'(TAP_CAP)) ? TAP_CAP : t_odd[TAP_W-1:0];
    end

    // floor(t / i) = (t * M) >> S, exact for t < 2^30
    always_comb
    begin
        case (i_reg)
            4'd2:    {recip_s, recip_m} = {6'd31, 32'd1073741824};
            4'd3:    {recip_s, recip_m} = {6'd32, 32'd1431655766};
            4'd4:    {recip_s, recip_m} = {6'd32, 32'd1073741824};
            4'd5:    {recip_s, recip_m} = {6'd33, 32'd1717986919};
            4'd6:    {recip_s, recip_m} = {6'd33, 32'd1431655766};
            4'd7:    {recip_s, recip_m} = {6'd33, 32'd1227133514};
            4'd8:    {recip_s, recip_m} = {6'd33, 32'd1073741824};
            4'd9:    {recip_s, recip_m} = {6'd34, 32'd1908874354};
            4'd10:   {recip_s, recip_m} = {6'd34, 32'd1717986919};
            default: {recip_s, recip_m} = {6'd30, 32'd1073741824};
        endcase
    end

    assign r_val = $signed({1'b0, x_reg, 1'b0}) - 25'sd65536;
    assign r_mag = r_val[24] ? 24'(-r_val) : r_val[23:0];

    assign l_mag = lprod_reg[54:16] + 40'd0;
    assign l_val = rneg_reg ? -$signed(l_mag) : $signed(l_mag);

    assign diff_mag = diff_reg[DIFF_W-1] ? (DIFF_W-1)'(-diff_reg)
                                         : diff_reg[DIFF_W-2:0];

    assign wr_en = (state_reg == S_WR);

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            m_tvalid_reg  <= 1'b0;
            div_start_reg <= 1'b0;
            gacc_reg      <= '0;
            lacc_reg      <= '0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        sigma_reg <= s_tdata[SIGMA_W-1:0];
                        state_reg <= S_SETUP;
                    end
                end
                S_SETUP:
                begin
                    n_reg     <= n_calc;
                    half_reg  <= n_calc >> 1;
                    ssq_reg   <= 22'(sigma_reg) * 22'(sigma_reg);
                    j_reg     <= '0;
                    gacc_reg  <= '0;
                    lacc_reg  <= '0;
                    state_reg <= S_P1_DIV;
                end
                S_P1_DIV:
                begin
                    if (sigma_reg == '0)
                    begin
                        x_reg     <= '0;
                        state_reg <= S_Y;
                    end
                    else
                    begin
                        div_ld_num_reg <= NUM_W'(tap_dist_sq) << 31;
                        div_ld_den_reg <= DEN_W'(ssq_reg);
                        div_start_reg  <= 1'b1;
                        state_reg      <= S_X_WAIT;
                    end
                end
                S_X_WAIT:
                begin
                    if (div_done_reg)
                    begin
                        x_reg <= (div_quo_reg > NUM_W'(X_LIMIT)) ? X_LIMIT
                                                                 : div_quo_reg[X_W-1:0];
                        state_reg <= S_Y;
                    end
                end
                S_Y:
                begin
                    y_reg     <= Y_W'((40'(x_reg) * 40'(LOG2E_Q16)) >> 16);
                    state_reg <= S_U;
                end
                S_U:
                begin
                    u_reg     <= U_W'((46'(y_reg[15:0]) * 46'(LN2_Q30)) >> 16);
                    k_reg     <= y_reg[23:16] + 8'd0;
                    term_reg  <= ONE_Q30;
                    sum_reg   <= 32'(ONE_Q30);
                    i_reg     <= 4'd1;
                    state_reg <= S_T_MUL;
                end
                S_T_MUL:
                begin
                    tprod_reg <= 30'((61'(term_reg) * 61'(u_reg)) >> 30);
                    state_reg <= S_T_DIV;
                end
                S_T_DIV:
                begin
                    tq_reg    <= TERM_W'((62'(tprod_reg) * 62'(recip_m)) >> recip_s);
                    state_reg <= S_T_WAIT;
                end
                S_T_WAIT:
                begin
                    term_reg <= tq_reg;
                    if (i_reg[0])
                        sum_reg <= sum_reg - 32'(tq_reg);
                    else
                        sum_reg <= sum_reg + 32'(tq_reg);
                    if (i_reg == 4'(TAYLOR_TERMS))
                        state_reg <= S_G;
                    else
                    begin
                        i_reg     <= i_reg + 4'd1;
                        state_reg <= S_T_MUL;
                    end
                end
                S_G:
                begin
                    g_reg     <= (k_reg >= 8'd30) ? '0 : TERM_W'(sum_reg >> k_reg[4:0]);
                    state_reg <= S_L;
                end
                S_L:
                begin
                    lprod_reg <= 55'(r_mag) * 55'(g_reg);
                    rneg_reg  <= r_val[24];
                    state_reg <= S_WR;
                end
                S_WR:
                begin
                    gacc_reg <= gacc_reg + ACC_W'(g_reg);
                    lacc_reg <= lacc_reg + l_val;
                    if (j_reg == n_reg - 6'd1)
                    begin
                        j_reg     <= '0;
                        state_reg <= S_P2;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 6'd1;
                        state_reg <= S_P1_DIV;
                    end
                end
                S_P2:
                begin
                    nden_reg  <= DEN_W'(n_reg) * DEN_W'(gacc_reg);
                    state_reg <= S_RD;
                end
                S_RD:
                begin
                    state_reg <= S_GC_START;
                end
                S_GC_START:
                begin
                    div_ld_num_reg <= (NUM_W'(g_rd_reg) << COEF_FRAC_BITS)
                                      + NUM_W'(gacc_reg >> 1);
                    div_ld_den_reg <= DEN_W'(gacc_reg);
                    div_start_reg  <= 1'b1;
                    diff_reg <= DIFF_W'($signed({1'b0, n_reg})) * DIFF_W'(l_rd_reg)
                                - DIFF_W'(lacc_reg);
                    state_reg <= S_GC_WAIT;
                end
                S_GC_WAIT:
                begin
                    if (div_done_reg)
                    begin
                        gauss_out_reg <= (div_quo_reg > NUM_W'(GC_MAX)) ? GC_MAX
                                                                         : div_quo_reg[COEF_W-1:0];
                        div_ld_num_reg <= (NUM_W'(diff_mag) << COEF_FRAC_BITS)
                                          + NUM_W'(nden_reg >> 1);
                        div_ld_den_reg <= nden_reg;
                        div_start_reg  <= 1'b1;
                        state_reg      <= S_LC_WAIT;
                    end
                end
                S_LC_WAIT:
                begin
                    if (div_done_reg)
                    begin
                        if (!diff_reg[DIFF_W-1])
                            log_out_reg <= (div_quo_reg > NUM_W'(LC_POS_MAX)) ? LC_POS_MAX
                                                                              : div_quo_reg[COEF_W-1:0];
                        else if (div_quo_reg > NUM_W'(LC_NEG_MAX))
                            log_out_reg <= LC_NEG_MAX;
                        else
                            log_out_reg <= -div_quo_reg[COEF_W-1:0];
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (m_tready)
                    begin
                        m_tvalid_reg <= 1'b0;
                        if (j_reg == n_reg - 6'd1)
                            state_reg <= S_IDLE;
                        else
                        begin
                            j_reg     <= j_reg + 6'd1;
                            state_reg <= S_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ---------------- shared restoring divider ----------------
    assign div_shift = {div_rem_reg, div_num_reg[NUM_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            div_done_reg <= 1'b0;
            if (div_start_reg)
            begin
                div_rem_reg  <= '0;
                div_quo_reg  <= '0;
                div_den_reg  <= div_ld_den_reg;
                div_num_reg  <= div_ld_num_reg;
                div_cnt_reg  <= CNT_W'(NUM_W);
                div_busy_reg <= 1'b1;
            end
            else if (div_busy_reg)
            begin
                if (div_shift >= {1'b0, div_den_reg})
                begin
                    div_rem_reg <= DEN_W'(div_shift - {1'b0, div_den_reg});
                    div_quo_reg <= {div_quo_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    div_rem_reg <= div_shift[DEN_W-1:0];
                    div_quo_reg <= {div_quo_reg[NUM_W-2:0], 1'b0};
                end
                div_num_reg <= div_num_reg << 1;
                div_cnt_reg <= div_cnt_reg - CNT_W'(1);
                if (div_cnt_reg == CNT_W'(1))
                begin
                    div_busy_reg <= 1'b0;
                    div_done_reg <= 1'b1;
                end
            end
        end
    end

    // ---------------- tap stores ----------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            gauss_store[j_reg] <= STORE_W'(g_reg);
            log_store[j_reg]   <= l_val[STORE_W-1:0];
        end
        g_rd_reg <= gauss_store[j_reg];
        l_rd_reg <= log_store[j_reg];
    end

    // ---------------- ports ----------------
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, gauss_out_reg, log_out_reg, n_reg, j_reg};
    assign m_tlast  = (j_reg == n_reg - 6'd1);

    // ---------------- assertions ----------------
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (j_reg < n_reg))
        else $error("tap index beyond tap count");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid && !div_busy_reg)
        else $error("ready while a kernel is in flight");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_done_reg |-> $past(div_busy_reg))
        else $error("divider done without running");

    a_count_odd: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> n_reg[0])
        else $error("even tap count");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> s_tready)
        else $error("block not idle after last tap");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for log_gauss_kernel_generator (one-axis LoG/Gauss taps).
// Depends on lgkg_pkg and the RTL top; predicts every tap beat in fixed point.
`timescale 1ns / 100ps

module testbench;
    import lgkg_pkg::*;

    typedef struct packed {
        logic [TAP_W-1:0]  tap_index;
        logic [TAP_W-1:0]  tap_count;
        logic [COEF_W-1:0] log_coef;
        logic [COEF_W-1:0] gauss_coef;
        logic              last;
    } tap_beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [10:0] sigma, [15:11] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // [5:0] tap_index, [11:6] tap_count, [28:12] log_coef,
                            // [45:29] gauss_coef
    logic        m_tlast;   // last

    tap_beat_t   expected_taps[$];
    int          mismatches;
    int          taps_seen;
    int          kernels_sent;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_cycles;

    log_gauss_kernel_generator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Builds the expected tap beats of one kernel.
    function automatic void predict_kernel(input logic [SIGMA_W-1:0] sigma);
        longint unsigned s, n, half, d, x, g, y, k, f, u, acc, term, gsum, gc, den, mag, q;
        longint          r, l, lsum, diff, lc;
        longint unsigned gauss_tap[STORE_DEPTH];
        longint          log_tap[STORE_DEPTH];
        tap_beat_t       beat;
        s = sigma;
        n = (10 * s) >> 8;
        if (n < 1)
            n = 1;
        if (n[0] == 1'b0)
            n = n + 1;
        if (n > 63)
            n = 63;
        half = (n - 1) / 2;
        gsum = 0;
        lsum = 0;
        for (longint unsigned j = 0; j < n; j++)
        begin
            d = (j >= half) ? j - half : half - j;
            x = (s != 0) ? ((d * d) << 31) / (s * s) : 0;
            if (x > X_LIMIT)
                x = X_LIMIT;
            // exp(-x): split into power of two and a Taylor series on the remainder
            y = (x * LOG2E_Q16) >> 16;
            k = y >> 16;
            f = y & 64'hFFFF;
            u = (f * LN2_Q30) >> 16;
            acc = 64'd1 << 30;
            term = 64'd1 << 30;
            for (longint unsigned i = 1; i <= TAYLOR_TERMS; i++)
            begin
                term = ((term * u) >> 30) / i;
                acc = i[0] ? acc - term : acc + term;
            end
            g = (k >= 30) ? 0 : acc >> k;
            r = longint'(2 * x) - 65536;
            l = (r >= 0) ? longint'((unsigned'(r) * g) >> 16)
                         : -longint'((unsigned'(-r) * g) >> 16);
            gauss_tap[j] = g;
            log_tap[j] = l;
            gsum += g;
            lsum += l;
        end
        for (longint unsigned j = 0; j < n; j++)
        begin
            gc = ((gauss_tap[j] << 16) + gsum / 2) / gsum;
            if (gc > GC_MAX)
                gc = GC_MAX;
            diff = longint'(n) * log_tap[j] - lsum;
            den = n * gsum;
            mag = (diff >= 0) ? unsigned'(diff) : unsigned'(-diff);
            q = ((mag << 16) + den / 2) / den;
            if (diff >= 0)
                lc = (q > 65535) ? 65535 : longint'(q);
            else
                lc = (q > 65536) ? -65536 : -longint'(q);
            beat.tap_index  = TAP_W'(j);
            beat.tap_count  = TAP_W'(n);
            beat.log_coef   = COEF_W'(lc);
            beat.gauss_coef = COEF_W'(gc);
            beat.last       = (j + 1 == n);
            expected_taps.push_back(beat);
        end
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        tap_beat_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.tap_index  = m_tdata[5:0];
            got.tap_count  = m_tdata[11:6];
            got.log_coef   = m_tdata[28:12];
            got.gauss_coef = m_tdata[45:29];
            got.last       = m_tlast;
            taps_seen++;
            if (expected_taps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected tap beat idx=%0d cnt=%0d",
                             got.tap_index, got.tap_count);
            end
            else
            begin
                want = expected_taps.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: tap mismatch exp idx=%0d cnt=%0d log=%0d ",
                                  "gauss=%0d last=%0d, got idx=%0d cnt=%0d log=%0d ",
                                  "gauss=%0d last=%0d"},
                                 want.tap_index, want.tap_count,
                                 $signed(want.log_coef), want.gauss_coef, want.last,
                                 got.tap_index, got.tap_count,
                                 $signed(got.log_coef), got.gauss_coef, got.last);
                end
            end
        end
    end

    // Receiver: random stalls, plus an optional long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_sigma(input logic [SIGMA_W-1:0] sigma);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {5'b0, sigma};
        do
            @(posedge clk);
        while (!s_tready);
        predict_kernel(sigma);
        kernels_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained;
        s_tvalid = 1'b0;
        while (expected_taps.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [SIGMA_W-1:0] pick_sigma;
        int sel;
        sel = $urandom_range(99);
        if (sel < 3)
            return SIGMA_W'($urandom_range(2047));
        else if (sel < 13)
            return SIGMA_W'($urandom_range(511));
        return SIGMA_W'($urandom_range(160));
    endfunction

    task automatic test_directed;
        logic [SIGMA_W-1:0] sigmas[$];
        // zero, single-tap edge, first even count, mid sizes, bit extremes, above range
        sigmas = '{11'd0, 11'd1, 11'd25, 11'd26, 11'd51, 11'd52, 11'd77, 11'd128,
                   11'd256, 11'd1023, 11'd1024, 11'd1600, 11'd1612, 11'd2047, 11'd3};
        send_idle_pct = 0;
        recv_stall_pct = 0;
        foreach (sigmas[i])
            send_sigma(sigmas[i]);
        wait_drained();
    endtask

    task automatic test_random(input int count, input int idle, input int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (count)
            send_sigma(pick_sigma());
        wait_drained();
    endtask

    task automatic test_output_hold_off;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(negedge clk);
        hold_off_cycles = 3000;
        repeat (4)
            send_sigma(SIGMA_W'($urandom_range(200)));
        wait_drained();
    endtask

    task automatic test_drain_pause;
        send_idle_pct = 0;
        recv_stall_pct = 33;
        repeat (5)
            send_sigma(pick_sigma());
        wait_drained();
        repeat (5)
            send_sigma(pick_sigma());
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        mismatches = 0;
        taps_seen = 0;
        kernels_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(75, 0, 0);
        test_random(75, 67, 0);
        test_random(75, 0, 67);
        test_random(75, 33, 33);
        test_output_hold_off();
        test_drain_pause();

        repeat (200) @(negedge clk);
        $display("Summary: %0d sigma beats (directed, random, hold-off, drain pause),",
                 kernels_sent);
        $display("         %0d tap beats checked, %0d mismatches", taps_seen, mismatches);
        if (mismatches == 0 && expected_taps.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("Timeout with %0d tap beats outstanding", expected_taps.size());
        $display("Verification failed");
        $finish;
    end

endmodule
